/* sv/atu_pkg.sv */
// ----------------------------------------------------------------------------
// atu_pkg
// Shared types and constants of the alarm table unit: operation and status
// codes, register indexes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package atu_pkg;

  localparam int ALARM_SLOTS_DEF = 16;
  localparam int TICK_BITS_DEF   = 16;

  localparam int OP_W      = 3;
  localparam int ID_W      = 5;
  localparam int VAL_W     = 16;
  localparam int STAT_W    = 3;
  localparam int REP_IDX_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_REPORTS = 16;
  localparam int RPT_W       = $clog2(MAX_REPORTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_SET_REL = 3'd0,
    OP_SET_ABS = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_GET     = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_ID      = 3'd1,
    ST_VALUE   = 3'd2,
    ST_STATE   = 3'd3,
    ST_NOFUNC  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ALLOWED = 2'd0,
    CFG_MIN_CYCLE   = 2'd1,
    CFG_EXT_CHECKS  = 2'd2
  } cfg_idx_t;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_OP   = 2'd1,
    S_SCAN = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic op_exec;
    logic scan_step;
    logic tick_finish;
  } atu_cmd_t;

  typedef struct packed {
    logic out_free;
    logic slot_match;
    logic scan_done;
    logic pend_valid;
  } atu_stat_t;

endpackage

/* sv/alarm_table_unit.sv */
// ----------------------------------------------------------------------------
// alarm_table_unit
// Alarm manager for one counter base: set relative/absolute, cancel, get
// remaining and counter tick over a table of alarm slots.
// ----------------------------------------------------------------------------
// Operation: the transfer loads the item registers and table read; the reply
//   is registered from S_OP once the result register is free.
// Tick: walks one slot per cycle through the table read port, held while a
//   pending expiry or the final result waits on a busy result register.
// A new item is taken only after the last one's final result is registered.
// Reset: clears all running flags, the result valid flag and the configuration
//   to its defaults at once; the expiration and period tables are not cleared.
// ----------------------------------------------------------------------------
module alarm_table_unit #(
  parameter int ALARM_SLOTS = atu_pkg::ALARM_SLOTS_DEF,
  parameter int TICK_BITS   = atu_pkg::TICK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [atu_pkg::OP_W-1:0]      in_opcode,
  input  logic [atu_pkg::ID_W-1:0]      in_alarm_id,
  input  logic [atu_pkg::VAL_W-1:0]     in_start_or_increment,
  input  logic [atu_pkg::VAL_W-1:0]     in_cycle_period,
  input  logic [atu_pkg::VAL_W-1:0]     in_counter_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [atu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atu_pkg::VAL_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [atu_pkg::STAT_W-1:0]    out_status,
  output logic [atu_pkg::VAL_W-1:0]     out_remaining_ticks,
  output logic [atu_pkg::REP_IDX_W-1:0] out_expired_alarm,
  output logic                          out_last
);

  atu_pkg::atu_cmd_t  cmd;
  atu_pkg::atu_stat_t stat;

  atu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  atu_datapath #(
    .ALARM_SLOTS (ALARM_SLOTS),
    .TICK_BITS   (TICK_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_opcode             (in_opcode),
    .in_alarm_id           (in_alarm_id),
    .in_start_or_increment (in_start_or_increment),
    .in_cycle_period       (in_cycle_period),
    .in_counter_value      (in_counter_value),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_status            (out_status),
    .out_remaining_ticks   (out_remaining_ticks),
    .out_expired_alarm     (out_expired_alarm),
    .out_last              (out_last),
    .cmd                   (cmd),
    .stat                  (stat)
  );

endmodule

/* sv/atu_ctrl.sv */
// ----------------------------------------------------------------------------
// atu_ctrl
// Sequencer of the alarm table unit: takes an item, runs one operation or
// walks the alarm slots for a tick, and waits on the result register.
// ----------------------------------------------------------------------------
module atu_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [atu_pkg::OP_W-1:0]       in_opcode,
  output logic                           in_ready,
  input  atu_pkg::atu_stat_t             stat,
  output atu_pkg::atu_cmd_t              cmd
);

  atu_pkg::state_t state_r;
  atu_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd.load        = 1'b0;
    cmd.op_exec     = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.tick_finish = 1'b0;
    case (state_r)
      atu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_opcode == atu_pkg::OP_TICK) begin
            state_nxt = atu_pkg::S_SCAN;
          end else begin
            state_nxt = atu_pkg::S_OP;
          end
        end
      end
      atu_pkg::S_OP: begin
        if (stat.out_free) begin
          cmd.op_exec = 1'b1;
          state_nxt   = atu_pkg::S_IDLE;
        end
      end
      atu_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.out_free) begin
            cmd.tick_finish = 1'b1;
            state_nxt       = atu_pkg::S_IDLE;
          end
        end else if (!(stat.slot_match && stat.pend_valid && !stat.out_free)) begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = atu_pkg::S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != atu_pkg::S_IDLE) |-> !in_ready)
    else $error("item taken while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == atu_pkg::S_OP || state_r == atu_pkg::S_SCAN))
    else $error("transfer did not start work");

  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.op_exec, cmd.scan_step, cmd.tick_finish}))
    else $error("conflicting commands");

endmodule

/* sv/atu_datapath.sv */
// ----------------------------------------------------------------------------
// atu_datapath
// Alarm tables, configuration registers, set/cancel/get arithmetic, tick
// slot evaluation with re-arm, pending expiry report and result register.
// ----------------------------------------------------------------------------
module atu_datapath #(
  parameter int ALARM_SLOTS = atu_pkg::ALARM_SLOTS_DEF,
  parameter int TICK_BITS   = atu_pkg::TICK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [atu_pkg::OP_W-1:0]          in_opcode,
  input  logic [atu_pkg::ID_W-1:0]          in_alarm_id,
  input  logic [atu_pkg::VAL_W-1:0]         in_start_or_increment,
  input  logic [atu_pkg::VAL_W-1:0]         in_cycle_period,
  input  logic [atu_pkg::VAL_W-1:0]         in_counter_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [atu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atu_pkg::VAL_W-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [atu_pkg::STAT_W-1:0]        out_status,
  output logic [atu_pkg::VAL_W-1:0]         out_remaining_ticks,
  output logic [atu_pkg::REP_IDX_W-1:0]     out_expired_alarm,
  output logic                              out_last,
  input  atu_pkg::atu_cmd_t                 cmd,
  output atu_pkg::atu_stat_t                stat
);

  localparam int IDX_W  = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int SCAN_W = $clog2(ALARM_SLOTS + 1);
  localparam int TB     = TICK_BITS;
  localparam int CMP_W  = (TICK_BITS > atu_pkg::VAL_W) ? TICK_BITS : atu_pkg::VAL_W;

  // configuration
  logic [atu_pkg::VAL_W-1:0] max_allowed_r;
  logic [atu_pkg::VAL_W-1:0] min_cycle_r;
  logic                      ext_checks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_allowed_r <= '1;
      min_cycle_r   <= atu_pkg::VAL_W'(1);
      ext_checks_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        atu_pkg::CFG_MAX_ALLOWED: max_allowed_r <= cfg_data;
        atu_pkg::CFG_MIN_CYCLE:   min_cycle_r   <= cfg_data;
        atu_pkg::CFG_EXT_CHECKS:  ext_checks_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item registers
  atu_pkg::op_t              item_op_r;
  logic [atu_pkg::ID_W-1:0]  item_id_r;
  logic [atu_pkg::VAL_W-1:0] item_arg_r;
  logic [atu_pkg::VAL_W-1:0] item_cyc_r;
  logic [TB-1:0]             item_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op_r  <= atu_pkg::op_t'(in_opcode);
      item_id_r  <= in_alarm_id;
      item_arg_r <= in_start_or_increment;
      item_cyc_r <= in_cycle_period;
      item_cnt_r <= TB'(in_counter_value);
    end
  end

  logic item_tick;
  assign item_tick = (item_op_r == atu_pkg::OP_TICK);

  // scan bookkeeping
  logic [SCAN_W-1:0]             scan_idx_r;
  logic [SCAN_W-1:0]             scan_inc;
  logic [atu_pkg::RPT_W-1:0]     rep_cnt_r;
  logic                          pend_valid_r;
  logic [atu_pkg::REP_IDX_W-1:0] pend_idx_r;

  assign scan_inc = scan_idx_r + SCAN_W'(1);

  // tables
  logic [TB-1:0]    exp_mem [ALARM_SLOTS];
  logic [TB-1:0]    per_mem [ALARM_SLOTS];
  logic [TB-1:0]    rd_exp_r;
  logic [TB-1:0]    rd_per_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] cur_addr_r;
  logic             running_r [ALARM_SLOTS];

  always_comb begin
    if (cmd.load) begin
      if (in_opcode == atu_pkg::OP_TICK) begin
        rd_addr = '0;
      end else begin
        rd_addr = IDX_W'(in_alarm_id);
      end
    end else if (cmd.scan_step) begin
      rd_addr = scan_inc[IDX_W-1:0];
    end else begin
      rd_addr = cur_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr_r <= rd_addr;
    rd_exp_r   <= exp_mem[rd_addr];
    rd_per_r   <= per_mem[rd_addr];
  end

  logic [IDX_W-1:0] item_idx;
  logic [IDX_W-1:0] eval_idx;
  logic             id_ok;
  logic             run_cur;

  assign item_idx = IDX_W'(item_id_r);
  assign eval_idx = item_tick ? scan_idx_r[IDX_W-1:0] : item_idx;
  assign id_ok    = (32'(item_id_r) < 32'(ALARM_SLOTS));
  assign run_cur  = running_r[eval_idx];

  // set arithmetic, shared by set operations and tick re-arm
  logic [CMP_W-1:0] max_c;
  logic [CMP_W-1:0] min_c;
  logic [TB-1:0]    max_tb;
  logic [TB-1:0]    inc_tb;
  logic [TB-1:0]    sum_tb;
  logic [TB-1:0]    wrap_tb;
  logic [CMP_W-1:0] start_c;
  logic [CMP_W-1:0] cycle_c;
  logic             bad_val;
  logic [TB-1:0]    rem_tb;

  assign max_c   = CMP_W'(max_allowed_r);
  assign min_c   = CMP_W'(min_cycle_r);
  assign max_tb  = TB'(max_allowed_r);
  assign inc_tb  = item_tick ? rd_per_r : TB'(item_arg_r);
  assign sum_tb  = item_cnt_r + inc_tb;
  assign wrap_tb = (CMP_W'(sum_tb) > max_c) ? (sum_tb - max_tb - TB'(1)) : sum_tb;
  assign start_c = (item_op_r == atu_pkg::OP_SET_ABS) ? CMP_W'(item_arg_r)
                                                      : CMP_W'(wrap_tb);
  assign cycle_c = item_tick ? CMP_W'(rd_per_r) : CMP_W'(item_cyc_r);
  assign bad_val = ext_checks_r &&
                   ((start_c > max_c) ||
                    ((cycle_c != '0) && ((cycle_c < min_c) || (cycle_c > max_c))));
  assign rem_tb  = (rd_exp_r >= item_cnt_r) ? (rd_exp_r - item_cnt_r)
                                            : (max_tb - item_cnt_r + rd_exp_r + TB'(1));

  // operation outcome
  atu_pkg::status_t op_status;
  logic             op_set;
  logic             op_clear;

  always_comb begin
    op_status = atu_pkg::ST_OK;
    op_set    = 1'b0;
    op_clear  = 1'b0;
    case (item_op_r)
      atu_pkg::OP_SET_REL, atu_pkg::OP_SET_ABS: begin
        if (!id_ok) begin
          op_status = atu_pkg::ST_ID;
        end else if ((item_op_r == atu_pkg::OP_SET_REL) && (item_arg_r == '0)) begin
          op_status = atu_pkg::ST_VALUE;
        end else if (bad_val) begin
          op_status = atu_pkg::ST_VALUE;
        end else if (run_cur) begin
          op_status = atu_pkg::ST_STATE;
        end else begin
          op_set = 1'b1;
        end
      end
      atu_pkg::OP_CANCEL: begin
        if (!id_ok) begin
          op_status = atu_pkg::ST_ID;
        end else if (!run_cur) begin
          op_status = atu_pkg::ST_NOFUNC;
        end else begin
          op_clear = 1'b1;
        end
      end
      atu_pkg::OP_GET: begin
        if (!id_ok) begin
          op_status = atu_pkg::ST_ID;
        end else if (!run_cur) begin
          op_status = atu_pkg::ST_NOFUNC;
        end
      end
      default: ;
    endcase
  end

  // tick slot evaluation
  logic slot_match;
  logic rearm_ok;
  logic scan_done;

  assign scan_done  = (scan_idx_r == SCAN_W'(ALARM_SLOTS)) ||
                      (rep_cnt_r == atu_pkg::RPT_W'(atu_pkg::MAX_REPORTS));
  assign slot_match = !scan_done && run_cur && (rd_exp_r == item_cnt_r);
  assign rearm_ok   = (rd_per_r != '0) && !bad_val;

  // table writes
  logic mem_we;
  logic flag_we;
  logic flag_val;

  assign mem_we   = (cmd.op_exec && op_set) || (cmd.scan_step && slot_match && rearm_ok);
  assign flag_we  = (cmd.op_exec && (op_set || op_clear)) || (cmd.scan_step && slot_match);
  assign flag_val = cmd.op_exec ? op_set : rearm_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      exp_mem[eval_idx] <= TB'(start_c);
      per_mem[eval_idx] <= TB'(cycle_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALARM_SLOTS; i++) begin
        running_r[i] <= 1'b0;
      end
    end else if (flag_we) begin
      running_r[eval_idx] <= flag_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load || cmd.tick_finish) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.scan_step && slot_match) begin
      pend_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx_r <= '0;
      rep_cnt_r  <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_inc;
      if (slot_match) begin
        rep_cnt_r  <= rep_cnt_r + atu_pkg::RPT_W'(1);
        pend_idx_r <= atu_pkg::REP_IDX_W'(scan_idx_r);
      end
    end
  end

  // result register
  logic                          out_valid_r;
  logic                          out_kind_r;
  atu_pkg::status_t              out_status_r;
  logic [atu_pkg::VAL_W-1:0]     out_rem_r;
  logic [atu_pkg::REP_IDX_W-1:0] out_idx_r;
  logic                          out_last_r;
  logic                          out_free;
  logic                          emit_pend;
  logic                          out_load;

  assign out_free  = !out_valid_r || out_ready;
  assign emit_pend = cmd.scan_step && slot_match && pend_valid_r;
  assign out_load  = cmd.op_exec || cmd.tick_finish || emit_pend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_exec) begin
      out_kind_r   <= atu_pkg::KIND_REPLY;
      out_status_r <= op_status;
      out_rem_r    <= ((item_op_r == atu_pkg::OP_GET) && id_ok && run_cur)
                      ? atu_pkg::VAL_W'(rem_tb) : '0;
      out_idx_r    <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.tick_finish || emit_pend) begin
      out_kind_r   <= pend_valid_r ? atu_pkg::KIND_EXPIRY : atu_pkg::KIND_REPLY;
      out_status_r <= atu_pkg::ST_OK;
      out_rem_r    <= '0;
      out_idx_r    <= pend_valid_r ? pend_idx_r : '0;
      out_last_r   <= cmd.tick_finish;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_status          = out_status_r;
  assign out_remaining_ticks = out_rem_r;
  assign out_expired_alarm   = out_idx_r;
  assign out_last            = out_last_r;

  assign stat.out_free   = out_free;
  assign stat.slot_match = slot_match;
  assign stat.scan_done  = scan_done;
  assign stat.pend_valid = pend_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_finish |=> (out_valid_r && out_last_r))
    else $error("tick closed without final result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step || cmd.tick_finish) |-> item_tick)
    else $error("scan on a non-tick item");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !scan_done)
    else $error("scan stepped past the end");

endmodule

/* verif/atu_result_checker.sv */
// ----------------------------------------------------------------------------
// atu_result_checker
// Watches the input, configuration and result channels of the alarm table
// unit. Keeps its own copy of the alarm table and registers, works out the
// results of every accepted item and compares each result transfer, field by
// field, against the oldest one due.
// ----------------------------------------------------------------------------
module atu_result_checker
  import atu_pkg::*;
#(
  parameter int SLOTS = ALARM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ID_W-1:0]      in_alarm_id,
  input  logic [VAL_W-1:0]     in_start_or_increment,
  input  logic [VAL_W-1:0]     in_cycle_period,
  input  logic [VAL_W-1:0]     in_counter_value,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_kind,
  input  logic [STAT_W-1:0]    out_status,
  input  logic [VAL_W-1:0]     out_remaining_ticks,
  input  logic [REP_IDX_W-1:0] out_expired_alarm,
  input  logic                 out_last,
  output int                   err_count,
  output int                   pend_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 kind;
    logic [STAT_W-1:0]    status;
    logic [VAL_W-1:0]     rem;
    logic [REP_IDX_W-1:0] slot;
    logic                 last;
  } alarm_result_t;

  alarm_result_t    due_results[$];
  alarm_result_t    want;
  logic [SLOTS-1:0] running;
  logic [VAL_W-1:0] expiry_tick [SLOTS];
  logic [VAL_W-1:0] cycle_ticks [SLOTS];
  logic [VAL_W-1:0] max_val;
  logic [VAL_W-1:0] min_cyc;
  logic             ext_on;

  initial err_count = 0;

  task automatic note_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic queue_result(logic kind, status_t st, logic [VAL_W-1:0] rem,
                              logic [REP_IDX_W-1:0] slot, logic last);
    alarm_result_t r;
    r.kind   = kind;
    r.status = st;
    r.rem    = rem;
    r.slot   = slot;
    r.last   = last;
    due_results.push_back(r);
  endtask

  function automatic logic [VAL_W-1:0] wrap_add(logic [VAL_W-1:0] base,
                                                logic [VAL_W-1:0] inc);
    logic [VAL_W-1:0] t;
    t = base + inc;
    if (t > max_val) begin
      t = t - (max_val + 16'd1);
    end
    return t;
  endfunction

  function automatic status_t arm_slot(int id, logic [VAL_W-1:0] start,
                                       logic [VAL_W-1:0] cyc);
    if (ext_on && start > max_val) begin
      return ST_VALUE;
    end
    if (ext_on && cyc != 0 && (cyc < min_cyc || cyc > max_val)) begin
      return ST_VALUE;
    end
    if (running[id]) begin
      return ST_STATE;
    end
    expiry_tick[id] = start;
    cycle_ticks[id] = cyc;
    running[id]     = 1'b1;
    return ST_OK;
  endfunction

  task automatic step_alarm_table(logic [OP_W-1:0] opc, logic [ID_W-1:0] id,
                                  logic [VAL_W-1:0] arg, logic [VAL_W-1:0] cyc,
                                  logic [VAL_W-1:0] cnt);
    status_t          st;
    logic [VAL_W-1:0] rem;
    int               n;
    st  = ST_OK;
    rem = '0;
    if (opc == OP_TICK) begin
      n = 0;
      for (int i = 0; i < SLOTS && n < MAX_REPORTS; i++) begin
        if (running[i] && expiry_tick[i] == cnt) begin
          running[i] = 1'b0;
          queue_result(KIND_EXPIRY, ST_OK, '0, REP_IDX_W'(i), 1'b0);
          n++;
          if (cycle_ticks[i] != 0) begin
            void'(arm_slot(i, wrap_add(cnt, cycle_ticks[i]), cycle_ticks[i]));
          end
        end
      end
      if (n == 0) begin
        queue_result(KIND_REPLY, ST_OK, '0, '0, 1'b1);
      end else begin
        due_results[$].last = 1'b1;
      end
      return;
    end
    if (opc <= OP_GET) begin
      if (id >= SLOTS) begin
        st = ST_ID;
      end else begin
        case (opc)
          OP_SET_REL: begin
            if (arg == 0) begin
              st = ST_VALUE;
            end else begin
              st = arm_slot(id, wrap_add(cnt, arg), cyc);
            end
          end
          OP_SET_ABS: st = arm_slot(id, arg, cyc);
          OP_CANCEL: begin
            if (!running[id]) begin
              st = ST_NOFUNC;
            end else begin
              running[id] = 1'b0;
            end
          end
          default: begin
            if (!running[id]) begin
              st = ST_NOFUNC;
            end else if (expiry_tick[id] >= cnt) begin
              rem = expiry_tick[id] - cnt;
            end else begin
              rem = max_val - cnt + expiry_tick[id] + 16'd1;
            end
          end
        endcase
      end
    end
    queue_result(KIND_REPLY, st, rem, '0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      running = '0;
      max_val = 16'hFFFF;
      min_cyc = 16'd1;
      ext_on  = 1'b1;
      due_results.delete();
      pend_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          note_error($sformatf("result with nothing due: kind %0d status %0d slot %0d",
                               out_kind, out_status, out_expired_alarm));
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind) begin
            note_error($sformatf("kind got %0d want %0d", out_kind, want.kind));
          end
          if (out_status !== want.status) begin
            note_error($sformatf("status got %0d want %0d", out_status, want.status));
          end
          if (out_remaining_ticks !== want.rem) begin
            note_error($sformatf("remaining_ticks got %0d want %0d",
                                 out_remaining_ticks, want.rem));
          end
          if (out_expired_alarm !== want.slot) begin
            note_error($sformatf("expired_alarm got %0d want %0d",
                                 out_expired_alarm, want.slot));
          end
          if (out_last !== want.last) begin
            note_error($sformatf("last got %0d want %0d", out_last, want.last));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_ALLOWED: max_val = cfg_data;
          CFG_MIN_CYCLE:   min_cyc = cfg_data;
          CFG_EXT_CHECKS:  ext_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_alarm_table(in_opcode, in_alarm_id, in_start_or_increment,
                         in_cycle_period, in_counter_value);
      end
      pend_count = due_results.size();
    end
  end

endmodule

/* verif/tb_alarm_table_unit.sv */
// ----------------------------------------------------------------------------
// tb_alarm_table_unit
// Drives the alarm table unit with a directed sequence and then random
// operations and counter ticks under six register settings, with random
// gaps on both channels and a long output hold-off. The result checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_alarm_table_unit;
  import atu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   PHASES         = 6;
  localparam int                   PHASE_ITEMS    = 48;
  localparam int                   DRAIN_CYCLES   = 2 * ALARM_SLOTS_DEF + 8;
  localparam int                   LONG_HOLD      = 400;
  localparam int                   WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      in_opcode;
  logic [ID_W-1:0]      in_alarm_id;
  logic [VAL_W-1:0]     in_start_or_increment;
  logic [VAL_W-1:0]     in_cycle_period;
  logic [VAL_W-1:0]     in_counter_value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_kind;
  logic [STAT_W-1:0]    out_status;
  logic [VAL_W-1:0]     out_remaining_ticks;
  logic [REP_IDX_W-1:0] out_expired_alarm;
  logic                 out_last;

  int   err_count;
  int   pend_count;
  int   idle_cycles;
  int   hold_token;
  logic calm;
  int   cnt_now;
  int   max_now;

  int max_tab [PHASES] = '{65535, 100, 1, 65535, 50, 2000};
  int min_tab [PHASES] = '{1, 5, 1, 65535, 3, 1};
  int ext_tab [PHASES] = '{1, 1, 1, 1, 0, 0};

  alarm_table_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_opcode             (in_opcode),
    .in_alarm_id           (in_alarm_id),
    .in_start_or_increment (in_start_or_increment),
    .in_cycle_period       (in_cycle_period),
    .in_counter_value      (in_counter_value),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_status            (out_status),
    .out_remaining_ticks   (out_remaining_ticks),
    .out_expired_alarm     (out_expired_alarm),
    .out_last              (out_last)
  );

  atu_result_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_opcode             (in_opcode),
    .in_alarm_id           (in_alarm_id),
    .in_start_or_increment (in_start_or_increment),
    .in_cycle_period       (in_cycle_period),
    .in_counter_value      (in_counter_value),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_status            (out_status),
    .out_remaining_ticks   (out_remaining_ticks),
    .out_expired_alarm     (out_expired_alarm),
    .out_last              (out_last),
    .err_count             (err_count),
    .pend_count            (pend_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_cycle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return '0;
    if (r < 80) return VAL_W'($urandom_range(1, 8));
    return VAL_W'($urandom);
  endfunction

  task automatic send_item(logic [OP_W-1:0] opc, logic [ID_W-1:0] id,
                           logic [VAL_W-1:0] arg, logic [VAL_W-1:0] cyc,
                           logic [VAL_W-1:0] cnt);
    int   gap;
    logic rdy;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_opcode             <= opc;
    in_alarm_id           <= id;
    in_start_or_increment <= arg;
    in_cycle_period       <= cyc;
    in_counter_value      <= cnt;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    logic rdy;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pend_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int               r;
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] arg;
    logic [VAL_W-1:0] cnt;
    r   = $urandom_range(0, 99);
    id  = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(16, 31))
                                      : ID_W'($urandom_range(0, 15));
    cnt = VAL_W'(cnt_now);
    if (r < 33) begin
      send_item(OP_TICK, ID_W'($urandom), VAL_W'($urandom), VAL_W'($urandom), cnt);
      cnt_now = (cnt_now >= max_now) ? 0 : cnt_now + 1;
    end else if (r < 58) begin
      if ($urandom_range(0, 19) == 0) begin
        arg = '0;
      end else if ($urandom_range(0, 4) != 0) begin
        arg = VAL_W'($urandom_range(1, 6));
      end else begin
        arg = VAL_W'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
        cnt = VAL_W'($urandom);
      end
      send_item(OP_SET_REL, id, arg, pick_cycle(), cnt);
    end else if (r < 70) begin
      if ($urandom_range(0, 3) != 0) begin
        arg = VAL_W'((cnt_now + $urandom_range(1, 6)) % (max_now + 1));
      end else begin
        arg = VAL_W'($urandom);
      end
      send_item(OP_SET_ABS, id, arg, pick_cycle(), cnt);
    end else if (r < 80) begin
      send_item(OP_CANCEL, id, VAL_W'($urandom), VAL_W'($urandom), cnt);
    end else if (r < 91) begin
      if ($urandom_range(0, 2) == 0) begin
        cnt = VAL_W'($urandom);
      end
      send_item(OP_GET, id, VAL_W'($urandom), VAL_W'($urandom), cnt);
    end else if (r < 96) begin
      send_item(OP_W'($urandom_range(0, 7)), ID_W'($urandom), VAL_W'($urandom),
                VAL_W'($urandom), VAL_W'($urandom));
    end else begin
      send_item(OP_TICK, id, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
    end
  endtask

  initial begin
    int seen;
    seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != seen) begin
        seen = hold_token;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        int off;
        off = pick_gap();
        if (off == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (off - 1) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    idle_cycles           = 0;
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_opcode             <= '0;
    in_alarm_id           <= '0;
    in_start_or_increment <= '0;
    in_cycle_period       <= '0;
    in_counter_value      <= '0;
    cfg_valid             <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    hold_token            <= 0;
    calm                  <= 1'b0;
    max_now = 65535;
    cnt_now = 100;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_SET_REL, 5'd31, 16'd5, 16'd0, 16'd100);
    send_item(OP_SET_REL, 5'd0, 16'd0, 16'd0, 16'd100);
    send_item(OP_SET_REL, 5'd0, 16'd5, 16'd0, 16'd100);
    send_item(OP_SET_REL, 5'd0, 16'd5, 16'd0, 16'd100);
    send_item(OP_GET, 5'd0, 16'd0, 16'd0, 16'd100);
    send_item(OP_GET, 5'd0, 16'd0, 16'd0, 16'd200);
    send_item(OP_SET_ABS, 5'd1, 16'hFFFF, 16'hFFFF, 16'd0);
    send_item(OP_CANCEL, 5'd1, 16'd0, 16'd0, 16'd0);
    send_item(OP_SET_REL, 5'd2, 16'hFFFF, 16'd0, 16'hFFFF);
    send_item(OP_TICK, 5'd0, 16'd0, 16'd0, 16'd105);
    send_item(OP_TICK, 5'd0, 16'd0, 16'd0, 16'hFFFE);
    send_item(OP_TICK, 5'd0, 16'd0, 16'd0, 16'd7);
    send_item(3'd7, 5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < ALARM_SLOTS_DEF; i++) begin
      send_item(OP_SET_ABS, ID_W'(i), 16'd500,
                (i % 3 == 0) ? 16'd0 : (i % 3 == 1) ? 16'd2 : 16'hFFFF, 16'd0);
    end
    send_item(OP_TICK, 5'd0, 16'd0, 16'd0, 16'd500);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(CFG_MAX_ALLOWED, VAL_W'(max_tab[ph]));
      write_reg(CFG_MIN_CYCLE, VAL_W'(min_tab[ph]));
      write_reg(CFG_EXT_CHECKS, {15'($urandom), 1'(ext_tab[ph])});
      if (ph == 1) begin
        write_reg(CFG_SPARE, VAL_W'($urandom));
      end
      max_now = max_tab[ph];
      cnt_now = $urandom_range(0, max_now);
      calm <= (ph == 3);
      if (ph == 0) begin
        hold_token <= hold_token + 1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_item();
        if (k == PHASE_ITEMS / 2) begin
          settle();
        end
      end
    end
    settle();

    if (err_count == 0 && pend_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/atu_pkg.sv
sv/atu_ctrl.sv
sv/atu_datapath.sv
sv/alarm_table_unit.sv
verif/atu_result_checker.sv
verif/tb_alarm_table_unit.sv
